>>> rtl/assb_pkg.sv
// shared constants and types for the azimuth source separation bin core
// no dependencies
package assb_pkg;

  localparam int unsigned IN_W          = 24;
  localparam int unsigned OUT_W         = 32;
  localparam int unsigned V_W           = 25;
  localparam int unsigned MUL_W         = 26;
  localparam int unsigned SQ_W          = 50;
  localparam int unsigned DVS_W         = 25;
  localparam int unsigned AMP_LO_W      = 17;
  localparam int unsigned MAX_STEPS_DEF = 255;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [7:0] STEPS_RST = 8'd100;
  localparam logic [8:0] FRAC_RST  = 9'd128;
  localparam logic [7:0] WIDTH_RST = 8'd2;
  localparam logic [8:0] FRAC_ONE  = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AZIMUTH_STEPS      = 2'd0,
    CFG_DIRECTION_FRACTION = 2'd1,
    CFG_WINDOW_WIDTH       = 2'd2
  } cfg_idx_e;

endpackage

>>> rtl/azimuth_source_separation_bin_core.sv
// azimuth source separation for one stereo spectral bin
// sequencer around a shared multiplier, restoring divider and bit-serial square root
// depends on assb_pkg
//
// usage: drive the four input parts and pulse start_i while busy_o is low; the
// request is taken at that edge and busy_o stays high until the result is out.
// the four separated parts appear with valid_o high for exactly one cycle, then
// busy_o drops in the next cycle. the receiver cannot stall the block.
// configuration goes through cfg_we_i / cfg_idx_i / cfg_data_i and is taken at
// once; write it only while busy_o is low.
// sequence: each plane first divides both parts of its gain operand by beta, then
// for each of the beta+1 gains squares the difference in two parts, takes its
// bit-serial square root and updates the minimum, maximum and count, and last
// forms its amplitude. each channel rescale squares its input, takes the root
// and, per part, multiplies by the amplitude and divides in the restoring divider,
// which makes one quotient bit a cycle (ACC_W = 57 with default parameters); a zero
// channel bin skips the root and the division and takes the amplitude directly.
// reset: asynchronous, returns the sequencer to idle and the registers to
// beta 100, direction 128/256, window 2. no clearing pass is needed.
module azimuth_source_separation_bin_core #(
  parameter int unsigned MAX_AZIMUTH_STEPS = assb_pkg::MAX_STEPS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  output logic                                valid_o,
  input  logic                                cfg_we_i,
  input  logic [assb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [assb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [assb_pkg::IN_W-1:0]    left_real_i,
  input  logic signed [assb_pkg::IN_W-1:0]    left_imag_i,
  input  logic signed [assb_pkg::IN_W-1:0]    right_real_i,
  input  logic signed [assb_pkg::IN_W-1:0]    right_imag_i,
  output logic signed [assb_pkg::OUT_W-1:0]   sep_left_real_o,
  output logic signed [assb_pkg::OUT_W-1:0]   sep_left_imag_o,
  output logic signed [assb_pkg::OUT_W-1:0]   sep_right_real_o,
  output logic signed [assb_pkg::OUT_W-1:0]   sep_right_imag_o
);
  import assb_pkg::*;

  localparam int unsigned BETA_W   = $clog2(MAX_AZIMUTH_STEPS + 1);
  localparam int unsigned CNT_W    = $clog2(MAX_AZIMUTH_STEPS + 2);
  localparam int unsigned AMP_W    = V_W + CNT_W;
  localparam int unsigned ACC_W    = AMP_W + IN_W - 1;
  localparam int unsigned DCNT_W   = $clog2(ACC_W + 1);
  localparam int unsigned CW       = 11;

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_PLOAD = 15'b000000000000010,
    ST_PDIV  = 15'b000000000000100,
    ST_SQR   = 15'b000000000001000,
    ST_SQI   = 15'b000000000010000,
    ST_ROOT  = 15'b000000000100000,
    ST_UPD   = 15'b000000001000000,
    ST_AMP   = 15'b000000010000000,
    ST_MSQR  = 15'b000000100000000,
    ST_MSQI  = 15'b000001000000000,
    ST_MROOT = 15'b000010000000000,
    ST_MULL  = 15'b000100000000000,
    ST_MULH  = 15'b001000000000000,
    ST_DIVR  = 15'b010000000000000,
    ST_DONE  = 15'b100000000000000
  } state_e;

  function automatic logic [IN_W-1:0] mag(input logic signed [IN_W-1:0] v);
    mag = v[IN_W-1] ? IN_W'(-v) : IN_W'(v);
  endfunction

  // control
  state_e              state_q;
  logic                plane_q, part_q, chan_q;
  logic [DCNT_W-1:0]   dcnt_q;
  logic [7:0]          steps_q;
  logic [8:0]          frac_q;
  logic [7:0]          width_q;

  // datapath
  logic signed [IN_W-1:0] lr_q, li_q, rr_q, ri_q;
  logic [BETA_W-1:0]      beta_q, lo_q, hi_q, i_q;
  logic [IN_W-1:0]        qb_q  [2];
  logic [BETA_W-1:0]      rb_q  [2];
  logic [IN_W-1:0]        acq_q [2];
  logic [BETA_W-1:0]      acr_q [2];
  logic [V_W-1:0]         mn_q, mx_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [AMP_W-1:0]       amp_q [2];
  logic [ACC_W-1:0]       acc_q, dq_q;
  logic [DVS_W-1:0]       drem_q, dvs_q, m_q;
  logic [SQ_W-1:0]        sv_q, sr_q, sbit_q;
  logic [OUT_W-1:0]       slr_q, sli_q, srr_q, sri_q;

  // window setup from configuration
  logic [CW-1:0]         st_x, beta_x, h_x, h2_x, d_x, lo_x, hi_x;
  logic [8:0]            frac_c;
  logic [BETA_W+8:0]     bf_c;
  logic [BETA_W-1:0]     beta_c;

  always_comb begin
    st_x = CW'(steps_q);
    if (st_x == '0) begin
      beta_x = CW'(1);
    end else if (st_x > CW'(MAX_AZIMUTH_STEPS)) begin
      beta_x = CW'(MAX_AZIMUTH_STEPS);
    end else begin
      beta_x = st_x;
    end
    beta_c = beta_x[BETA_W-1:0];
    frac_c = (frac_q > FRAC_ONE) ? FRAC_ONE : frac_q;
    h_x = CW'(width_q);
    if (h_x == '0) begin
      h_x = CW'(1);
    end
    if (h_x > beta_x) begin
      h_x = beta_x;
    end
    h2_x = h_x >> 1;
    bf_c = (BETA_W+9)'(beta_c) * (BETA_W+9)'(frac_c);
    d_x  = CW'(bf_c >> 8);
    lo_x = (d_x >= h2_x) ? d_x - h2_x : '0;
    hi_x = (d_x + h2_x > beta_x) ? beta_x : d_x + h2_x;
  end

  // plane operands
  logic signed [IN_W-1:0] a_re, a_im, b_re, b_im;
  logic signed [MUL_W-1:0] cdiff [2];
  logic [BETA_W:0]         rsum [2];
  logic                    wrap [2];

  always_comb begin
    a_re = plane_q ? rr_q : lr_q;
    a_im = plane_q ? ri_q : li_q;
    b_re = plane_q ? lr_q : rr_q;
    b_im = plane_q ? li_q : ri_q;
    for (int k = 0; k < 2; k++) begin
      logic [IN_W:0]           g;
      logic signed [MUL_W-1:0] gb;
      logic                    bneg;
      g    = (IN_W+1)'(acq_q[k]) +
             (IN_W+1)'({acr_q[k], 1'b0} >= {1'b0, beta_q});
      bneg = (k == 0) ? b_re[IN_W-1] : b_im[IN_W-1];
      gb   = bneg ? -MUL_W'(g) : MUL_W'(g);
      cdiff[k] = ((k == 0) ? MUL_W'(a_re) : MUL_W'(a_im)) - gb;
      rsum[k]  = {1'b0, acr_q[k]} + {1'b0, rb_q[k]};
      wrap[k]  = rsum[k] >= {1'b0, beta_q};
    end
  end

  // rescale operands
  logic signed [IN_W-1:0] x_re, x_im, xp;
  logic [AMP_W-1:0]       amp_sel;
  logic [IN_W-1:0]        pb_abs;

  always_comb begin
    x_re    = chan_q ? rr_q : lr_q;
    x_im    = chan_q ? ri_q : li_q;
    xp      = part_q ? x_im : x_re;
    amp_sel = chan_q ? amp_q[0] : amp_q[1];
    pb_abs  = part_q ? mag(b_im) : mag(b_re);
  end

  // shared multiplier
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  logic [ACC_W-1:0]          mul_u, acc_sum;

  always_comb begin
    case (state_q)
      ST_SQR: begin
        mul_a = cdiff[0];
        mul_b = cdiff[0];
      end
      ST_SQI: begin
        mul_a = cdiff[1];
        mul_b = cdiff[1];
      end
      ST_AMP: begin
        mul_a = MUL_W'(cnt_q);
        mul_b = MUL_W'(mx_q - mn_q);
      end
      ST_MSQR: begin
        mul_a = MUL_W'(x_re);
        mul_b = MUL_W'(x_re);
      end
      ST_MSQI: begin
        mul_a = MUL_W'(x_im);
        mul_b = MUL_W'(x_im);
      end
      ST_MULL: begin
        mul_a = MUL_W'(amp_sel[AMP_LO_W-1:0]);
        mul_b = MUL_W'(mag(xp));
      end
      ST_MULH: begin
        mul_a = MUL_W'(amp_sel[AMP_W-1:AMP_LO_W]);
        mul_b = MUL_W'(mag(xp));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p   = mul_a * mul_b;
    mul_u   = ACC_W'(mul_p[2*MUL_W-2:0]);
    acc_sum = acc_q + mul_u;
  end

  // divider and square root steps
  logic [DVS_W:0]    div_rs;
  logic              div_ge;
  logic [SQ_W-1:0]   sq_t;
  logic              sq_ge;

  always_comb begin
    div_rs = {drem_q, dq_q[ACC_W-1]};
    div_ge = div_rs >= {1'b0, dvs_q};
    sq_t   = sr_q + sbit_q;
    sq_ge  = sv_q >= sq_t;
  end

  // final rounding and saturation
  logic [ACC_W:0]     qr;
  logic [OUT_W-1:0]   fin_v, amp_sat;
  logic [ACC_W-1:0]   amp_x;
  logic [V_W-1:0]     root_v;
  logic               in_win;

  always_comb begin
    qr = (ACC_W+1)'(dq_q) + (ACC_W+1)'({drem_q, 1'b0} >= {1'b0, dvs_q});
    if (!xp[IN_W-1]) begin
      fin_v = (qr > (ACC_W+1)'(32'h7fff_ffff)) ? 32'h7fff_ffff : qr[OUT_W-1:0];
    end else begin
      fin_v = (qr > (ACC_W+1)'(32'h8000_0000)) ? 32'h8000_0000 : -qr[OUT_W-1:0];
    end
    amp_x   = ACC_W'(amp_sel);
    amp_sat = (amp_x > ACC_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : amp_x[OUT_W-1:0];
    root_v  = sr_q[V_W-1:0];
    in_win  = (i_q >= lo_q) && (i_q <= hi_q);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plane_q <= 1'b0;
      part_q  <= 1'b0;
      chan_q  <= 1'b0;
      dcnt_q  <= '0;
      steps_q <= STEPS_RST;
      frac_q  <= FRAC_RST;
      width_q <= WIDTH_RST;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_AZIMUTH_STEPS:      steps_q <= cfg_data_i[7:0];
          CFG_DIRECTION_FRACTION: frac_q  <= cfg_data_i;
          CFG_WINDOW_WIDTH:       width_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            plane_q <= 1'b0;
            part_q  <= 1'b0;
            state_q <= ST_PLOAD;
          end
        end
        ST_PLOAD: begin
          dcnt_q  <= DCNT_W'(ACC_W);
          state_q <= ST_PDIV;
        end
        ST_PDIV: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 1'b1;
          end else if (!part_q) begin
            part_q  <= 1'b1;
            state_q <= ST_PLOAD;
          end else begin
            state_q <= ST_SQR;
          end
        end
        ST_SQR: state_q <= ST_SQI;
        ST_SQI: state_q <= ST_ROOT;
        ST_ROOT: begin
          if (sbit_q == '0) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: state_q <= (i_q == beta_q) ? ST_AMP : ST_SQR;
        ST_AMP: begin
          if (!plane_q) begin
            plane_q <= 1'b1;
            part_q  <= 1'b0;
            state_q <= ST_PLOAD;
          end else begin
            chan_q  <= 1'b0;
            state_q <= ST_MSQR;
          end
        end
        ST_MSQR: state_q <= ST_MSQI;
        ST_MSQI: begin
          if (acc_sum != '0) begin
            state_q <= ST_MROOT;
          end else if (!chan_q) begin
            chan_q  <= 1'b1;
            state_q <= ST_MSQR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_MROOT: begin
          if (sbit_q == '0) begin
            part_q  <= 1'b0;
            state_q <= ST_MULL;
          end
        end
        ST_MULL: state_q <= ST_MULH;
        ST_MULH: begin
          dcnt_q  <= DCNT_W'(ACC_W);
          state_q <= ST_DIVR;
        end
        ST_DIVR: begin
          if (dcnt_q != '0) begin
            dcnt_q <= dcnt_q - 1'b1;
          end else if (!part_q) begin
            part_q  <= 1'b1;
            state_q <= ST_MULL;
          end else if (!chan_q) begin
            chan_q  <= 1'b1;
            state_q <= ST_MSQR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          lr_q   <= left_real_i;
          li_q   <= left_imag_i;
          rr_q   <= right_real_i;
          ri_q   <= right_imag_i;
          beta_q <= beta_c;
          lo_q   <= lo_x[BETA_W-1:0];
          hi_q   <= hi_x[BETA_W-1:0];
        end
      end
      ST_PLOAD: begin
        dq_q   <= ACC_W'(pb_abs);
        drem_q <= '0;
        dvs_q  <= DVS_W'(beta_q);
      end
      ST_PDIV: begin
        if (dcnt_q != '0) begin
          drem_q <= div_ge ? DVS_W'(div_rs - {1'b0, dvs_q}) : div_rs[DVS_W-1:0];
          dq_q   <= {dq_q[ACC_W-2:0], div_ge};
        end else begin
          qb_q[part_q] <= dq_q[IN_W-1:0];
          rb_q[part_q] <= drem_q[BETA_W-1:0];
          if (part_q) begin
            i_q      <= '0;
            acq_q[0] <= '0;
            acq_q[1] <= '0;
            acr_q[0] <= '0;
            acr_q[1] <= '0;
            mn_q     <= '1;
            mx_q     <= '0;
            cnt_q    <= '0;
          end
        end
      end
      ST_SQR, ST_MSQR, ST_MULL: acc_q <= mul_u;
      ST_SQI: begin
        sv_q   <= acc_sum[SQ_W-1:0];
        sr_q   <= '0;
        sbit_q <= SQ_W'(1) << (SQ_W - 2);
      end
      ST_ROOT, ST_MROOT: begin
        if (sbit_q != '0) begin
          if (sq_ge) begin
            sv_q <= sv_q - sq_t;
            sr_q <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end else if (state_q == ST_MROOT) begin
          m_q <= sr_q[DVS_W-1:0];
        end
      end
      ST_UPD: begin
        if (root_v < mn_q) begin
          mn_q  <= root_v;
          cnt_q <= CNT_W'(in_win);
        end else if (root_v == mn_q) begin
          cnt_q <= cnt_q + CNT_W'(in_win);
        end
        if (root_v > mx_q) begin
          mx_q <= root_v;
        end
        if (i_q != beta_q) begin
          i_q <= i_q + 1'b1;
          for (int k = 0; k < 2; k++) begin
            acr_q[k] <= wrap[k] ? BETA_W'(rsum[k] - {1'b0, beta_q}) : rsum[k][BETA_W-1:0];
            acq_q[k] <= acq_q[k] + qb_q[k] + IN_W'(wrap[k]);
          end
        end
      end
      ST_AMP: amp_q[plane_q] <= AMP_W'(mul_u);
      ST_MSQI: begin
        sv_q   <= acc_sum[SQ_W-1:0];
        sr_q   <= '0;
        sbit_q <= SQ_W'(1) << (SQ_W - 2);
        if (acc_sum == '0) begin
          if (chan_q) begin
            srr_q <= amp_sat;
            sri_q <= '0;
          end else begin
            slr_q <= amp_sat;
            sli_q <= '0;
          end
        end
      end
      ST_MULH: begin
        dq_q   <= acc_sum + (mul_u << AMP_LO_W) - mul_u;
        drem_q <= '0;
        dvs_q  <= m_q;
      end
      ST_DIVR: begin
        if (dcnt_q != '0) begin
          drem_q <= div_ge ? DVS_W'(div_rs - {1'b0, dvs_q}) : div_rs[DVS_W-1:0];
          dq_q   <= {dq_q[ACC_W-2:0], div_ge};
        end else begin
          case ({chan_q, part_q})
            2'b00:   slr_q <= fin_v;
            2'b01:   sli_q <= fin_v;
            2'b10:   srr_q <= fin_v;
            default: sri_q <= fin_v;
          endcase
        end
      end
      default: ;
    endcase
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign valid_o          = (state_q == ST_DONE);
  assign sep_left_real_o  = slr_q;
  assign sep_left_imag_o  = sli_q;
  assign sep_right_real_o = srr_q;
  assign sep_right_imag_o = sri_q;

endmodule

>>> rtl/assb_checker.sv
// port-level checks on the request and result handshake of the bin core
// bound to azimuth_source_separation_bin_core; no other dependencies
module assb_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic valid_o
);

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("busy not raised after request");

  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !valid_o)
    else $error("result strobe right after request");

  a_valid_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o)
    else $error("result strobe while idle");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> (!valid_o && !busy_o))
    else $error("result strobe not single or busy held");

endmodule

bind azimuth_source_separation_bin_core assb_checker u_assb_checker (.*);

>>> tb/azimuth_source_separation_bin_core_tb.sv
// testbench for the azimuth source separation bin core: directed and random requests
// checked against an in-bench predictor of the azimuth planes and the rescale
// depends on assb_pkg and azimuth_source_separation_bin_core
`timescale 1ns / 100ps

module azimuth_source_separation_bin_core_tb;
  import assb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned MAX_STEPS = 255;
  localparam longint CYCLE_LIMIT = 80_000_000;
  localparam int unsigned RANDOM_ITEMS = 1120;

  typedef struct packed {
    logic signed [IN_W-1:0] lr;
    logic signed [IN_W-1:0] li;
    logic signed [IN_W-1:0] rr;
    logic signed [IN_W-1:0] ri;
  } bin_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] lr;
    logic signed [OUT_W-1:0] li;
    logic signed [OUT_W-1:0] rr;
    logic signed [OUT_W-1:0] ri;
  } sep_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, valid_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic signed [IN_W-1:0] left_real_i = '0, left_imag_i = '0;
  logic signed [IN_W-1:0] right_real_i = '0, right_imag_i = '0;
  logic signed [OUT_W-1:0] sep_left_real_o, sep_left_imag_o;
  logic signed [OUT_W-1:0] sep_right_real_o, sep_right_imag_o;

  logic [7:0] steps_reg;
  logic [8:0] frac_reg;
  logic [7:0] width_reg;
  sep_t pending_sep[$];
  int unsigned mismatches = 0;
  longint cycles = 0;

  azimuth_source_separation_bin_core dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .valid_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .left_real_i, .left_imag_i, .right_real_i, .right_imag_i,
    .sep_left_real_o, .sep_left_imag_o, .sep_right_real_o, .sep_right_imag_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic longint div_nearest(longint num, longint den);
    longint m, q;
    m = num < 0 ? -num : num;
    q = (m + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = longint'(1) <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint null_amplitude(longint ar, longint ai, longint br, longint bi,
                                            longint beta, longint lo, longint hi);
    longint mag[0:MAX_STEPS];
    longint mn, mx, cr, ci, sum;
    mn = 64'sh7fff_ffff_ffff_ffff;
    mx = 0;
    sum = 0;
    for (longint i = 0; i <= beta; i++) begin
      cr = ar - div_nearest(i * br, beta);
      ci = ai - div_nearest(i * bi, beta);
      mag[i] = root_floor(cr * cr + ci * ci);
      if (mag[i] < mn) mn = mag[i];
      if (mag[i] > mx) mx = mag[i];
    end
    for (longint i = lo; i <= hi; i++)
      if (mag[i] == mn) sum += mx - mn;
    return sum;
  endfunction

  function automatic logic signed [OUT_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[OUT_W-1:0];
  endfunction

  function automatic sep_t separate_bin(bin_t b);
    sep_t s;
    longint beta, frac, h, h2, d, lo, hi, amp_l, amp_r, m, lr, li, rr, ri;
    lr = b.lr; li = b.li; rr = b.rr; ri = b.ri;
    beta = steps_reg;
    frac = frac_reg;
    h = width_reg;
    if (beta < 1) beta = 1;
    if (beta > MAX_STEPS) beta = MAX_STEPS;
    if (frac > 256) frac = 256;
    if (h < 1) h = 1;
    if (h > beta) h = beta;
    h2 = h / 2;
    d = (beta * frac) / 256;
    lo = d >= h2 ? d - h2 : 0;
    hi = d + h2 > beta ? beta : d + h2;
    amp_r = null_amplitude(lr, li, rr, ri, beta, lo, hi);
    amp_l = null_amplitude(rr, ri, lr, li, beta, lo, hi);
    if (lr == 0 && li == 0) begin
      s.lr = clip32(amp_l);
      s.li = '0;
    end else begin
      m = root_floor(lr * lr + li * li);
      s.lr = clip32(div_nearest(amp_l * lr, m));
      s.li = clip32(div_nearest(amp_l * li, m));
    end
    if (rr == 0 && ri == 0) begin
      s.rr = clip32(amp_r);
      s.ri = '0;
    end else begin
      m = root_floor(rr * rr + ri * ri);
      s.rr = clip32(div_nearest(amp_r * rr, m));
      s.ri = clip32(div_nearest(amp_r * ri, m));
    end
    return s;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("azimuth_source_separation_bin_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    sep_t want, got;
    if (rst_ni && valid_o) begin
      got = {sep_left_real_o, sep_left_imag_o, sep_right_real_o, sep_right_imag_o};
      if (pending_sep.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_sep.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                     want.lr, want.li, want.rr, want.ri, got.lr, got.li, got.rr, got.ri);
        end
      end
    end
  end

  task automatic send_bin(bin_t b);
    @(posedge clk_i);
    start_i <= 1'b1;
    left_real_i <= b.lr;
    left_imag_i <= b.li;
    right_real_i <= b.rr;
    right_imag_i <= b.ri;
    do @(posedge clk_i); while (busy_o);
    pending_sep.push_back(separate_bin(b));
    start_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_sep.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_AZIMUTH_STEPS: steps_reg = data[7:0];
      CFG_DIRECTION_FRACTION: frac_reg = data;
      CFG_WINDOW_WIDTH: width_reg = data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int steps, int frac, int width);
    write_reg(CFG_AZIMUTH_STEPS, CFG_DATA_W'(steps));
    write_reg(CFG_DIRECTION_FRACTION, CFG_DATA_W'(frac));
    write_reg(CFG_WINDOW_WIDTH, CFG_DATA_W'(width));
  endtask

  function automatic logic signed [IN_W-1:0] any24();
    return IN_W'($urandom());
  endfunction

  function automatic logic signed [IN_W-1:0] small24();
    return IN_W'($urandom_range(0, 16) - 8);
  endfunction

  function automatic bin_t random_bin();
    bin_t b;
    longint k;
    b = {any24(), any24(), any24(), any24()};
    k = $urandom_range(0, 256);
    case ($urandom_range(0, 9))
      0, 1: ;
      2: b = {small24(), small24(), small24(), small24()};
      3: begin
        b.lr = IN_W'((longint'(b.rr) * k) / 256);
        b.li = IN_W'((longint'(b.ri) * k) / 256);
      end
      4: begin
        b.rr = IN_W'((longint'(b.lr) * k) / 256);
        b.ri = IN_W'((longint'(b.li) * k) / 256);
      end
      5: begin
        b.li = '0;
        b.ri = '0;
      end
      6: if ($urandom_range(0, 1)) b.lr = '0; else {b.rr, b.ri} = '0;
      default: begin
        b.lr = IN_W'((longint'(b.rr) * k) / 256 + small24());
        b.li = IN_W'((longint'(b.ri) * k) / 256 + small24());
      end
    endcase
    return b;
  endfunction

  task automatic test_reset_setting;
    bin_t dir[$];
    dir = '{
      '{24'sh7fffff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff},
      '{24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000},
      '{24'sh7fffff, 24'sh800000, 24'sh800000, 24'sh7fffff},
      '{'0, '0, '0, '0},
      '{'0, '0, 24'sh400000, 24'sh123456},
      '{24'sh3abcde, 24'sh765432, '0, '0},
      '{24'sh200000, '0, 24'sh200000, '0},
      '{24'sh200000, 24'sh100000, 24'sh100000, 24'sh080000},
      '{24'sd1, '0, 24'sd1, '0},
      '{'0, '0, 24'sd1, '0},
      '{24'sh555555, 24'shaaaaaa, 24'shaaaaaa, 24'sh555555},
      '{24'sd3, 24'sh800000, 24'sh7fffff, -24'sd3}
    };
    foreach (dir[i]) send_bin(dir[i]);
  endtask

  task automatic test_register_extremes;
    int set[$][3];
    set = '{'{1, 0, 1}, '{0, 511, 0}, '{255, 256, 255}, '{7, 300, 255},
            '{16, 0, 200}, '{3, 256, 1}, '{255, 128, 0}};
    foreach (set[i]) begin
      set_config(set[i][0], set[i][1], set[i][2]);
      send_bin(random_bin());
      send_bin('{24'sh100000, 24'sh080000, 24'sh100000, 24'sh080000});
    end
    write_reg(CFG_UNUSED_IDX, 9'h1ff);
    send_bin(random_bin());
  endtask

  task automatic test_random_bins;
    int unsigned sent, burst, steps;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steps = $urandom_range(0, 19) == 0 ? $urandom_range(17, 255) : $urandom_range(0, 16);
      set_config(steps,
                 $urandom_range(0, 3) == 0 ? $urandom_range(257, 511) : $urandom_range(0, 256),
                 $urandom_range(0, 4) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12));
      for (int n = 0; n < 40 && sent < RANDOM_ITEMS; ) begin
        burst = $urandom_range(1, 8);
        for (int j = 0; j < burst; j++, n++, sent++) send_bin(random_bin());
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(0, 40)) @(posedge clk_i);
        if ($urandom_range(0, 15) == 0) drain();
      end
    end
  endtask

  initial begin
    steps_reg = STEPS_RST;
    frac_reg = FRAC_RST;
    width_reg = WIDTH_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_setting();
    drain();
    test_register_extremes();
    test_random_bins();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_sep.size() == 0) begin
      $display("azimuth_source_separation_bin_core: match");
    end else begin
      $display("azimuth_source_separation_bin_core: mismatch");
    end
    $finish;
  end

endmodule

>>> azimuth_source_separation_bin_core.f
rtl/assb_pkg.sv
rtl/azimuth_source_separation_bin_core.sv
rtl/assb_checker.sv
tb/azimuth_source_separation_bin_core_tb.sv
